FILE: hw/rtl/mfdf_pkg.sv
// ----------------------------------------------------------------------------
// mfdf_pkg
// Shared types and constants of the mesh flood duplicate filter.
// ----------------------------------------------------------------------------
package mfdf_pkg;

  localparam int unsigned TABLE_ENTRIES    = 64;
  localparam int unsigned CLEANUP_INTERVAL = 16;
  localparam int unsigned MIN_HEADER_BYTES = 12;

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned SCAN_W = IDX_W + 1;
  localparam int unsigned CNT_W  = $clog2(CLEANUP_INTERVAL + 1);
  localparam int unsigned FLEN_W = 9;

  localparam logic [31:0] BROADCAST_ID  = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_AGE_RESET = 32'd60;

  // verdict codes
  localparam logic [1:0] VERDICT_SHORT = 2'd0;
  localparam logic [1:0] VERDICT_DUP   = 2'd1;
  localparam logic [1:0] VERDICT_NEW   = 2'd2;

  // register indexes
  localparam logic REG_OWN_ID  = 1'b0;
  localparam logic REG_MAX_AGE = 1'b1;

  typedef struct packed {
    logic [31:0] src;
    logic [15:0] seq;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_INSERT,
    ST_SWEEP,
    ST_RESULT
  } state_e;

endpackage

FILE: hw/rtl/mesh_flood_duplicate_filter.sv
// Flow: a short frame goes straight to its result word, a duplicate ends the table search
//   at its first match, a new header walks the whole table and is then inserted, and
//   every CLEANUP_INTERVAL-th insert adds an aging sweep over the table.
// Throughput: one header at a time; the single read port of the table memory is walked
//   one entry per cycle.
// Reset: control, pointers and per-entry valid flops clear asynchronously; no clearing pass.
// ----------------------------------------------------------------------------
// mesh_flood_duplicate_filter
// Duplicate cache and deliver/forward decision for flood-routed mesh headers.
// ----------------------------------------------------------------------------
module mesh_flood_duplicate_filter
  import mfdf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // header input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       source_id_i,
  input  logic [31:0]       dest_id_i,
  input  logic [15:0]       seq_number_i,
  input  logic [7:0]        hops_left_i,
  input  logic [FLEN_W-1:0] frame_length_i,
  input  logic [31:0]       now_seconds_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        verdict_o,
  output logic              deliver_o,
  output logic              forward_o,
  output logic [7:0]        forward_hops_o
);

  state_e state_q, state_d;

  // configuration registers
  logic [31:0] own_id_q, max_age_q;
  logic        cfg_we;

  // latched header
  logic [31:0] src_q, dst_q, now_q;
  logic [15:0] seq_q;
  logic [7:0]  hops_q;
  logic [1:0]  verdict_q, verdict_d;

  // table memory and its read pipeline
  entry_t                   mem_q [TABLE_ENTRIES];
  entry_t                   rd_entry_q;
  entry_t                   ent_view;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [SCAN_W-1:0]        scan_q, scan_d;
  logic [IDX_W-1:0]         raddr;
  logic [IDX_W-1:0]         cidx_q;
  logic                     pend_q, pend_last_q, hit_vld_q;
  logic [IDX_W-1:0]         ptr_q;
  logic [CNT_W-1:0]         cnt_q;

  // control
  logic mem_re, mem_we, sweep_clr, load_out, out_free;
  logic match, aged, for_us, fwd;
  logic [31:0] age;

  // result registers
  logic       out_valid_q;
  logic [1:0] verdict_out_q;
  logic       deliver_q, forward_q;
  logic [7:0] fwd_hops_q;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q  <= '0;
      max_age_q <= MAX_AGE_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_OWN_ID:  own_id_q  <= pwdata;
        REG_MAX_AGE: max_age_q <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OWN_ID:  prdata = own_id_q;
      REG_MAX_AGE: prdata = max_age_q;
      default:     prdata = '0;
    endcase
  end

  // ---------------- compare logic ----------------
  assign raddr    = scan_q[IDX_W-1:0];
  assign ent_view = hit_vld_q ? rd_entry_q : '0;
  assign match    = (ent_view.src == src_q) && (ent_view.seq == seq_q);
  assign age      = now_q - rd_entry_q.stamp;
  // zero stamp never ages out
  assign aged     = hit_vld_q && (rd_entry_q.stamp != '0) && (age > max_age_q);
  assign out_free = !out_valid_q || out_ready_i;

  // ---------------- next state ----------------
  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    verdict_d = verdict_q;
    case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        if (in_valid_i) begin
          if (frame_length_i < FLEN_W'(MIN_HEADER_BYTES)) begin
            verdict_d = VERDICT_SHORT;
            state_d   = ST_RESULT;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (mem_re) scan_d = scan_q + SCAN_W'(1);
        if (pend_q && match) begin
          verdict_d = VERDICT_DUP;
          state_d   = ST_RESULT;
        end else if (pend_q && pend_last_q) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: begin
        scan_d    = '0;
        verdict_d = VERDICT_NEW;
        if (cnt_q == CNT_W'(CLEANUP_INTERVAL - 1)) state_d = ST_SWEEP;
        else                                       state_d = ST_RESULT;
      end
      ST_SWEEP: begin
        if (mem_re) scan_d = scan_q + SCAN_W'(1);
        if (pend_q && pend_last_q) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    sweep_clr  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SEARCH: mem_re = (scan_q < SCAN_W'(TABLE_ENTRIES));
      ST_INSERT: mem_we = 1'b1;
      ST_SWEEP: begin
        mem_re    = (scan_q < SCAN_W'(TABLE_ENTRIES));
        sweep_clr = pend_q && aged;
      end
      ST_RESULT: load_out = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      verdict_q   <= VERDICT_SHORT;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      verdict_q   <= verdict_d;
      pend_q      <= mem_re;
      pend_last_q <= mem_re && (raddr == IDX_W'(TABLE_ENTRIES - 1));
      if (mem_we) begin
        ptr_q <= (ptr_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : ptr_q + IDX_W'(1);
        cnt_q <= (cnt_q == CNT_W'(CLEANUP_INTERVAL - 1)) ? '0 : cnt_q + CNT_W'(1);
      end
    end
  end

  // latch the header word on acceptance
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      src_q  <= source_id_i;
      dst_q  <= dest_id_i;
      seq_q  <= seq_number_i;
      hops_q <= hops_left_i;
      now_q  <= now_seconds_i;
    end
  end

  // ---------------- table memory ----------------
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[ptr_q] <= '{src: src_q, seq: seq_q, stamp: now_q};
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_entry_q <= mem_q[raddr];
      hit_vld_q  <= valid_q[raddr];
      cidx_q     <= raddr;
    end
  end

  // aged entries drop back to the reset value by losing their valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (mem_we)    valid_q[ptr_q]  <= 1'b1;
      if (sweep_clr) valid_q[cidx_q] <= 1'b0;
    end
  end

  // ---------------- result register ----------------
  assign for_us = (dst_q == own_id_q) || (dst_q == BROADCAST_ID);
  assign fwd    = (verdict_q == VERDICT_NEW) && !for_us && (hops_q > 8'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      verdict_out_q <= verdict_q;
      deliver_q     <= (verdict_q == VERDICT_NEW) && for_us;
      forward_q     <= fwd;
      fwd_hops_q    <= fwd ? hops_q - 8'd1 : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_o      = verdict_out_q;
  assign deliver_o      = deliver_q;
  assign forward_o      = forward_q;
  assign forward_hops_o = fwd_hops_q;

endmodule

FILE: hw/rtl/mfdf_checker.sv
// ----------------------------------------------------------------------------
// mfdf_checker
// Port-level checks of the mesh flood duplicate filter.
// ----------------------------------------------------------------------------
module mfdf_checker
  import mfdf_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] verdict_o,
  input logic       deliver_o,
  input logic       forward_o,
  input logic [7:0] forward_hops_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o)
      && $stable(deliver_o) && $stable(forward_o) && $stable(forward_hops_o))
    else $error("stalled result word changed");

  // dropped headers carry no routing decision
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o != VERDICT_NEW |->
      !deliver_o && !forward_o && forward_hops_o == 8'd0)
    else $error("dropped header has routing fields set");

  // forward excludes deliver and never sends a zero hop count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && forward_o |-> !deliver_o && forward_hops_o != 8'd0)
    else $error("bad forward decision");

  // one header at a time: busy right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second header taken while busy");

endmodule

bind mesh_flood_duplicate_filter mfdf_checker u_mfdf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .verdict_o      (verdict_o),
  .deliver_o      (deliver_o),
  .forward_o      (forward_o),
  .forward_hops_o (forward_hops_o)
);
